// ===== rtl/rsti_pkg.sv =====
// ----------------------------------------------------------------------------
// rsti_pkg
// Shared types, constants and helpers for the radix string to int64 converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rsti_pkg;

  localparam int CHAR_W   = 8;
  localparam int RADIX_W  = 6;
  localparam int VALUE_W  = 64;
  localparam int MAG_W    = VALUE_W - 1;
  localparam int STATUS_W = 2;
  localparam int DIGIT_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;

  localparam logic [DIGIT_W-1:0] DIGIT_NONE   = 7'd64;
  localparam logic [DIGIT_W-1:0] LETTER_BASE  = 7'd10;

  typedef logic [CHAR_W-1:0]   char_t;
  typedef logic [RADIX_W-1:0]  radix_t;
  typedef logic [VALUE_W-1:0]  value_t;
  typedef logic [MAG_W-1:0]    mag_t;
  typedef logic [DIGIT_W-1:0]  digit_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_INVALID  = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic {
    CTL_READY = 1'b0,
    CTL_HOLD  = 1'b1
  } ctl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic step;   // take a non-terminator byte
    logic load;   // terminator: latch result, clear accumulator
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic term;   // current input byte is the terminator
  } dp_stat_t;

  function automatic digit_t digit_of(input char_t c);
    digit_t d;
    d = DIGIT_NONE;
    if (c >= CH_0 && c <= CH_9) begin
      d = DIGIT_W'(c - CH_0);
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = DIGIT_W'(c - CH_UA) + LETTER_BASE;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = DIGIT_W'(c - CH_LA) + LETTER_BASE;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rsti_if.sv =====
// ----------------------------------------------------------------------------
// rsti_char_if / rsti_res_if
// Valid/ready channels for input bytes and conversion results.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsti_char_if;
  import rsti_pkg::*;
  logic  valid;
  logic  ready;
  char_t char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface rsti_res_if;
  import rsti_pkg::*;
  logic    valid;
  logic    ready;
  value_t  value;
  status_t status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/rsti_ctrl.sv =====
// ----------------------------------------------------------------------------
// rsti_ctrl
// Handshake controller: accepts bytes and holds the result slot until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rsti_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire rsti_pkg::dp_stat_t stat,
  output rsti_pkg::ctl_cmd_t      cmd
);
  import rsti_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       accept;

  always_comb begin
    in_ready = 1'b1;
    case (state_r)
      CTL_READY: in_ready = 1'b1;
      CTL_HOLD:  in_ready = out_ready;
      default:   in_ready = 1'b0;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CTL_READY: begin
        if (accept && stat.term) state_nxt = CTL_HOLD;
      end
      CTL_HOLD: begin
        // slot frees when taken; a terminator in the same cycle refills it
        if (out_ready) state_nxt = (accept && stat.term) ? CTL_HOLD : CTL_READY;
      end
      default: state_nxt = CTL_READY;
    endcase
  end

  always_comb begin
    out_valid = (state_r == CTL_HOLD);
    cmd.step  = accept && !stat.term;
    cmd.load  = accept && stat.term;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= CTL_READY;
    else        state_r <= state_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/rsti_dp.sv =====
// ----------------------------------------------------------------------------
// rsti_dp
// Datapath: radix register, digit decode, multiply-accumulate, overflow check
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rsti_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire rsti_pkg::radix_t     cfg_wdata,
  input  wire rsti_pkg::char_t      char_code,
  input  wire rsti_pkg::ctl_cmd_t   cmd,
  output rsti_pkg::dp_stat_t        stat,
  output rsti_pkg::value_t          value,
  output rsti_pkg::status_t         status
);
  import rsti_pkg::*;

  localparam int PROD_W = MAG_W + RADIX_W;
  localparam int SUM_W  = PROD_W + 1;

  radix_t  radix_r;
  mag_t    mag_r, mag_nxt;
  logic    neg_r, neg_nxt;
  logic    first_r, first_nxt;
  status_t err_r, err_nxt;
  value_t  value_r;
  status_t status_r;

  radix_t             base;
  digit_t             digit;
  logic [PROD_W-1:0]  prod;
  logic [SUM_W-1:0]   sum;
  value_t             signed_val;

  assign stat.term = (char_code == CH_NUL);

  always_comb begin
    if (radix_r < RADIX_MIN)      base = RADIX_MIN;
    else if (radix_r > RADIX_MAX) base = RADIX_MAX;
    else                          base = radix_r;
  end

  assign digit = digit_of(char_code);
  assign prod  = PROD_W'(mag_r) * PROD_W'(base);
  assign sum   = SUM_W'(prod) + SUM_W'(digit);

  always_comb begin
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    first_nxt = first_r;
    err_nxt   = err_r;
    if (cmd.load) begin
      mag_nxt   = '0;
      neg_nxt   = 1'b0;
      first_nxt = 1'b1;
      err_nxt   = STATUS_OK;
    end else if (cmd.step && err_r == STATUS_OK) begin
      first_nxt = 1'b0;
      if (first_r && char_code == CH_MINUS) begin
        neg_nxt = 1'b1;
      end else if (digit >= DIGIT_W'(base)) begin
        err_nxt = STATUS_INVALID;
      end else if (sum[SUM_W-1:MAG_W] != '0) begin
        err_nxt = STATUS_OVERFLOW;
      end else begin
        mag_nxt = sum[MAG_W-1:0];
      end
    end
  end

  always_comb begin
    signed_val = {1'b0, mag_r};
    if (neg_r) signed_val = ~signed_val + VALUE_W'(1);
    if (err_r != STATUS_OK) signed_val = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
      mag_r   <= '0;
      neg_r   <= 1'b0;
      first_r <= 1'b1;
      err_r   <= STATUS_OK;
    end else begin
      if (cfg_we) radix_r <= cfg_wdata;
      mag_r   <= mag_nxt;
      neg_r   <= neg_nxt;
      first_r <= first_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r  <= signed_val;
      status_r <= err_r;
    end
  end

  assign value  = value_r;
  assign status = status_r;

endmodule

`default_nettype wire

// ===== rtl/radix_string_to_int64.sv =====
// Latency: the result is valid the cycle after the terminator transaction.
// Throughput: one byte per cycle; the 63x6 multiply-add with its overflow
//   check completes in the cycle the byte is taken.
// While a result waits, a byte is taken only in a cycle where out_ch.ready is
//   high, so a stalled result stalls the input.
// Reset (rst_n, synchronous): radix returns to 10, accumulator cleared.
// ----------------------------------------------------------------------------
// radix_string_to_int64
// Converts a NUL-terminated byte string in a configurable radix to int64.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_string_to_int64 (
  input  wire logic              clk,
  input  wire logic              rst_n,
  rsti_char_if.sink              in_ch,
  rsti_res_if.source             out_ch,
  input  wire logic              cfg_we,
  input  wire rsti_pkg::radix_t  cfg_wdata
);
  import rsti_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  rsti_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rsti_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .char_code (in_ch.char_code),
    .cmd       (cmd),
    .stat      (stat),
    .value     (out_ch.value),
    .status    (out_ch.status)
  );

  // terminator transaction always produces a result next cycle
  a_term_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.char_code == CH_NUL) |=> out_ch.valid)
    else $error("terminator did not produce a result");

  a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != STATUS_OK) |-> (out_ch.value == '0))
    else $error("nonzero value on error status");

  a_step_load_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.step && cmd.load))
    else $error("step and load both issued");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.status == STATUS_OK || out_ch.status == STATUS_INVALID ||
                      out_ch.status == STATUS_OVERFLOW))
    else $error("illegal status code");

endmodule

`default_nettype wire
